// ----- design/hard_sphere_metropolis_move_assert.svh -----
// Assertion macros for the move engine
`ifndef HARD_SPHERE_METROPOLIS_MOVE_ASSERT_SVH
`define HARD_SPHERE_METROPOLIS_MOVE_ASSERT_SVH
`ifndef SYNTH
`define HSM_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("%m: implication failed");
`define HSM_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("%m: next-cycle check failed");
`else
`define HSM_ASSERT_IMP(label, clk, rst_n, a, c)
`define HSM_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- design/hsm_pkg.sv -----
package hsm_pkg;
  localparam int MAX_PARTICLES_DEF = 512;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int POS_W   = 24;
  localparam int RAND_W  = 17;
  localparam int STEP_W  = 17;
  localparam int COUNT_W = 10;
  localparam int TOT_W   = 32;
  localparam int IDX_W   = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_LOADED   = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   particle_index;
    logic [POS_W-1:0]   load_x;
    logic [POS_W-1:0]   load_y;
    logic [POS_W-1:0]   load_z;
    logic [RAND_W-1:0]  rand_x;
    logic [RAND_W-1:0]  rand_y;
    logic [RAND_W-1:0]  rand_z;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
    logic [TOT_W-1:0]   accepted_total;
    logic [TOT_W-1:0]   rejected_total;
  } rsp_t;
endpackage

// ----- design/hsm_stream_if.sv -----
interface hsm_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/hsm_image_sq.sv -----
// Minimum-image squared distance along one axis, registered.
module hsm_image_sq (
  input  logic                      clk,
  input  logic [hsm_pkg::POS_W-1:0] a,
  input  logic [hsm_pkg::POS_W-1:0] b,
  input  logic [hsm_pkg::POS_W-1:0] box,
  output logic [2*hsm_pkg::POS_W+1:0] sq_r
);
  import hsm_pkg::*;
  logic signed [POS_W+2:0] t, t2, l, m;
  logic [POS_W+1:0] mag, mag_r;
  always_comb begin
    t = $signed({3'b0, a}) - $signed({3'b0, b});
    l = $signed({3'b0, box});
    t2 = t <<< 1;
    if (t2 > l) m = t - l;
    else if (t2 < -l) m = t + l;
    else m = t;
    mag = m[POS_W+2] ? (POS_W+2)'(-m) : (POS_W+2)'(m);
  end
  always_ff @(posedge clk) begin
    mag_r <= mag;
    sq_r <= (2*POS_W+2)'(mag_r) * (2*POS_W+2)'(mag_r);
  end
endmodule

// ----- design/hard_sphere_metropolis_move.sv -----
// Channel | Direction | Payload
// in      | sink      | op, particle_index, load_x/y/z, rand_x/y/z
// out     | source    | status, pos_x/y/z, accepted_total, rejected_total
// cfg     | write     | cfg_we, cfg_index, cfg_data
// A load writes its position straight to memory; a move scans min(count, MAX_PARTICLES) particles,
// one stored particle per cycle through the single read port of the position memory.
// Reset clears control state and counters; the memory is not cleared.
// One item is in work at a time; in_ready holds low until the result is taken.
module hard_sphere_metropolis_move #(
  parameter int MAX_PARTICLES = hsm_pkg::MAX_PARTICLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hsm_stream_if.sink                    in_ch,
  hsm_stream_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [hsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsm_pkg::CFG_W-1:0]     cfg_data
);
  import hsm_pkg::*;
  `include "hard_sphere_metropolis_move_assert.svh"

  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = AW + 1;
  localparam int SQW = 2*POS_W + 2;
  localparam logic [SQW+1:0] LIMIT = (SQW+2)'(1) << (2*FRAC_BITS);
  localparam logic [AW-1:0] LAST = AW'(MAX_PARTICLES - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDOLD = 7'b0000010,
    S_PROD  = 7'b0000100,
    S_PROP  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_WB    = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [POS_W-1:0] box_x_r, box_y_r, box_z_r;
  logic [STEP_W-1:0] step_r;
  logic [COUNT_W-1:0] count_r;
  req_t req_r;
  logic [AW-1:0] idx_r;
  logic [3*POS_W-1:0] mem [MAX_PARTICLES];
  logic [3*POS_W-1:0] rd_r;
  logic [3*POS_W-1:0] old_r;
  logic [AW-1:0] rd_addr;
  logic we;
  logic [AW-1:0] wr_addr;
  logic [3*POS_W-1:0] wr_data;
  logic [POS_W-1:0] cx_r, cy_r, cz_r;
  logic signed [RAND_W+STEP_W+1:0] px_r, py_r, pz_r;
  logic [CW-1:0] scan_r, n_lim;
  logic [2:0] pipe_v_r, pipe_self_r;
  logic hit_r;
  logic [SQW-1:0] sqx, sqy, sqz;
  logic [TOT_W-1:0] acc_r, rej_r;
  rsp_t rsp_r;
  logic accepted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= POS_W'(524288);
      box_y_r <= POS_W'(524288);
      box_z_r <= POS_W'(524288);
      step_r  <= STEP_W'(3277);
      count_r <= COUNT_W'(500);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_X: box_x_r <= cfg_data;
        REG_BOX_Y: box_y_r <= cfg_data;
        REG_BOX_Z: box_z_r <= cfg_data;
        REG_STEP:  step_r  <= cfg_data[STEP_W-1:0];
        REG_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(count_r) > 32'(MAX_PARTICLES)) n_lim = CW'(MAX_PARTICLES);
    else n_lim = CW'(count_r);
  end

  function automatic logic signed [RAND_W+STEP_W+1:0] prod_f(
      input logic [RAND_W-1:0] r, input logic [STEP_W-1:0] s);
    logic signed [RAND_W+1:0] d;
    d = $signed({1'b0, r, 1'b0}) - $signed((RAND_W+2)'(1) << FRAC_BITS);
    return d * $signed({1'b0, s});
  endfunction

  function automatic logic [POS_W-1:0] prop_f(
      input logic [POS_W-1:0] old, input logic signed [RAND_W+STEP_W+1:0] p,
      input logic [POS_W-1:0] box);
    logic signed [RAND_W+STEP_W+1:0] d;
    logic signed [POS_W+2:0] c;
    d = p >>> FRAC_BITS;
    c = $signed({3'b0, old}) + (POS_W+3)'(d);
    if (c > $signed({3'b0, box})) c = c - $signed({3'b0, box});
    else if (c < 0) c = c + $signed({3'b0, box});
    return c[POS_W-1:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = (in_ch.data.op == OP_LOAD) ? S_WB : S_RDOLD;
      S_RDOLD: state_nxt = S_PROD;
      S_PROD:  state_nxt = S_PROP;
      S_PROP:  state_nxt = S_SCAN;
      S_SCAN:  if (scan_r >= n_lim && pipe_v_r == 3'b0) state_nxt = S_WB;
      S_WB:    state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = idx_r;
    if (state_r == S_SCAN || state_r == S_PROP) rd_addr = scan_r[AW-1:0];
  end

  assign accepted = !hit_r;
  always_comb begin
    we = 1'b0;
    wr_addr = idx_r;
    wr_data = {req_r.load_x, req_r.load_y, req_r.load_z};
    if (state_r == S_WB) begin
      if (req_r.op == OP_LOAD) we = 1'b1;
      else if (accepted) begin
        we = 1'b1;
        wr_data = {cx_r, cy_r, cz_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  hsm_image_sq u_sq_x (.clk, .a(cx_r), .b(rd_r[3*POS_W-1:2*POS_W]), .box(box_x_r),
    .sq_r(sqx));
  hsm_image_sq u_sq_y (.clk, .a(cy_r), .b(rd_r[2*POS_W-1:POS_W]), .box(box_y_r),
    .sq_r(sqy));
  hsm_image_sq u_sq_z (.clk, .a(cz_r), .b(rd_r[POS_W-1:0]), .box(box_z_r), .sq_r(sqz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r <= '0;
      rej_r <= '0;
      pipe_v_r <= '0;
      hit_r <= 1'b0;
      scan_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r <= in_ch.data;
            idx_r <= (32'(in_ch.data.particle_index) >= 32'(MAX_PARTICLES)) ? LAST
                     : AW'(in_ch.data.particle_index);
          end
          hit_r <= 1'b0;
          scan_r <= '0;
          pipe_v_r <= '0;
        end
        S_PROD: begin
          px_r <= prod_f(req_r.rand_x, step_r);
          py_r <= prod_f(req_r.rand_y, step_r);
          pz_r <= prod_f(req_r.rand_z, step_r);
        end
        S_PROP: begin
          old_r <= rd_r;
          cx_r <= prop_f(rd_r[3*POS_W-1:2*POS_W], px_r, box_x_r);
          cy_r <= prop_f(rd_r[2*POS_W-1:POS_W], py_r, box_y_r);
          cz_r <= prop_f(rd_r[POS_W-1:0], pz_r, box_z_r);
          scan_r <= scan_r + CW'(1);
          pipe_v_r <= {pipe_v_r[1:0], (scan_r < n_lim)};
          pipe_self_r <= {pipe_self_r[1:0], (scan_r[AW-1:0] == idx_r)};
        end
        S_SCAN: begin
          if (scan_r < n_lim) scan_r <= scan_r + CW'(1);
          pipe_v_r <= {pipe_v_r[1:0], (scan_r < n_lim)};
          pipe_self_r <= {pipe_self_r[1:0], (scan_r[AW-1:0] == idx_r)};
          if (pipe_v_r[2] && !pipe_self_r[2] &&
              ((SQW+2)'(sqx) + (SQW+2)'(sqy) + (SQW+2)'(sqz)) < LIMIT)
            hit_r <= 1'b1;
        end
        S_WB: begin
          if (req_r.op == OP_MOVE) begin
            if (accepted) acc_r <= acc_r + TOT_W'(1);
            else rej_r <= rej_r + TOT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WB) begin
      rsp_r.accepted_total <= acc_r;
      rsp_r.rejected_total <= rej_r;
      if (req_r.op == OP_LOAD) begin
        rsp_r.status <= ST_LOADED;
        {rsp_r.pos_x, rsp_r.pos_y, rsp_r.pos_z} <= wr_data;
      end else if (accepted) begin
        rsp_r.status <= ST_ACCEPTED;
        rsp_r.accepted_total <= acc_r + TOT_W'(1);
        {rsp_r.pos_x, rsp_r.pos_y, rsp_r.pos_z} <= {cx_r, cy_r, cz_r};
      end else begin
        rsp_r.status <= ST_REJECTED;
        rsp_r.rejected_total <= rej_r + TOT_W'(1);
        rsp_r.pos_x <= old_r[3*POS_W-1:2*POS_W];
        rsp_r.pos_y <= old_r[2*POS_W-1:POS_W];
        rsp_r.pos_z <= old_r[POS_W-1:0];
      end
    end
  end

  // Hold the old position from the proposal step for a rejected report.

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = rsp_r;

  `HSM_ASSERT_IMP(a_no_write_in_scan, clk, rst_n, state_r == S_SCAN, !we)
  `HSM_ASSERT_NEXT(a_count_one_step, clk, rst_n,
    state_r == S_WB && req_r.op == OP_MOVE,
    (acc_r + rej_r) == ($past(acc_r) + $past(rej_r) + TOT_W'(1)))
  `HSM_ASSERT_IMP(a_out_holds_idle_in, clk, rst_n, out_ch.valid, !in_ch.ready)
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import hsm_pkg::*;

  localparam int NPART = MAX_PARTICLES_DEF;
  localparam longint ONE = 64'd1 << FRAC_BITS_DEF;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  hsm_stream_if #(.payload_t(req_t)) in_ch ();
  hsm_stream_if #(.payload_t(rsp_t)) out_ch ();

  hard_sphere_metropolis_move u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  req_t req_q[$];
  rsp_t move_result_q[$];

  logic [POS_W-1:0] sphere_x[NPART];
  logic [POS_W-1:0] sphere_y[NPART];
  logic [POS_W-1:0] sphere_z[NPART];
  logic [TOT_W-1:0] n_accept, n_reject;
  longint lbox_x, lbox_y, lbox_z, lstep;
  int scan_count;

  bit loaded[NPART];
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic logic [POS_W-1:0] displace(logic [POS_W-1:0] old,
                                                logic [RAND_W-1:0] r, longint box);
    longint o, rr, c;
    o = old;
    rr = r;
    c = o + (((2 * rr - ONE) * lstep) >>> FRAC_BITS_DEF);
    if (c > box) c = c - box;
    else if (c < 0) c = c + box;
    return c[POS_W-1:0];
  endfunction

  function automatic longint image_sq(logic [POS_W-1:0] a, logic [POS_W-1:0] b, longint box);
    longint t, aa, bb;
    aa = a;
    bb = b;
    t = aa - bb;
    if (2 * t > box) t = t - box;
    else if (2 * t < -box) t = t + box;
    return t * t;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int idx, n;
    logic [POS_W-1:0] cx, cy, cz;
    bit hit;
    idx = r.particle_index;
    if (r.op == OP_LOAD) begin
      sphere_x[idx] = r.load_x;
      sphere_y[idx] = r.load_y;
      sphere_z[idx] = r.load_z;
      res.status = ST_LOADED;
    end else begin
      cx = displace(sphere_x[idx], r.rand_x, lbox_x);
      cy = displace(sphere_y[idx], r.rand_y, lbox_y);
      cz = displace(sphere_z[idx], r.rand_z, lbox_z);
      n = (scan_count > NPART) ? NPART : scan_count;
      hit = 0;
      for (int i = 0; i < n; i++) begin
        if (i != idx && !hit) begin
          if (image_sq(cx, sphere_x[i], lbox_x) + image_sq(cy, sphere_y[i], lbox_y)
              + image_sq(cz, sphere_z[i], lbox_z) < ONE * ONE) hit = 1;
        end
      end
      if (hit) begin
        n_reject = n_reject + 1;
        res.status = ST_REJECTED;
      end else begin
        sphere_x[idx] = cx;
        sphere_y[idx] = cy;
        sphere_z[idx] = cz;
        n_accept = n_accept + 1;
        res.status = ST_ACCEPTED;
      end
    end
    res.pos_x = sphere_x[idx];
    res.pos_y = sphere_y[idx];
    res.pos_z = sphere_z[idx];
    res.accepted_total = n_accept;
    res.rejected_total = n_reject;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) move_result_q.push_back(apply_request(in_ch.data));
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= req_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go) hold_left <= 2000;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (move_result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
        end else begin
          want = move_result_q.pop_front();
          if (out_ch.data.status !== want.status || out_ch.data.pos_x !== want.pos_x ||
              out_ch.data.pos_y !== want.pos_y || out_ch.data.pos_z !== want.pos_z ||
              out_ch.data.accepted_total !== want.accepted_total ||
              out_ch.data.rejected_total !== want.rejected_total) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, out_ch.data);
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL hard_sphere_metropolis_move");
      $finish;
    end
  end

  task automatic wait_idle();
    while (req_q.size() > 0 || move_result_q.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BOX_X: lbox_x = val;
      REG_BOX_Y: lbox_y = val;
      REG_BOX_Z: lbox_z = val;
      REG_STEP: lstep = val[STEP_W-1:0];
      REG_COUNT: scan_count = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic req_t noise_req();
    req_t r;
    r = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return r;
  endfunction

  task automatic push_load(int idx, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                           logic [POS_W-1:0] z);
    req_t r;
    r = noise_req();
    r.op = OP_LOAD;
    r.particle_index = IDX_W'(idx);
    r.load_x = x;
    r.load_y = y;
    r.load_z = z;
    loaded[idx] = 1;
    req_q.push_back(r);
  endtask

  task automatic push_move(int idx, logic [RAND_W-1:0] rx, logic [RAND_W-1:0] ry,
                           logic [RAND_W-1:0] rz);
    req_t r;
    r = noise_req();
    r.op = OP_MOVE;
    r.particle_index = IDX_W'(idx);
    r.rand_x = rx;
    r.rand_y = ry;
    r.rand_z = rz;
    req_q.push_back(r);
  endtask

  function automatic logic [POS_W-1:0] rand_pos(longint box);
    if ($urandom_range(19) == 0) return POS_W'($urandom);
    return POS_W'($urandom_range(32'(box - 1)));
  endfunction

  function automatic logic [RAND_W-1:0] rand_frac();
    if ($urandom_range(9) == 0) return RAND_W'($urandom);
    return RAND_W'($urandom_range(65536));
  endfunction

  task automatic configure(longint bx, longint by, longint bz, longint st, int cnt);
    set_reg(REG_BOX_X, CFG_W'(bx));
    set_reg(REG_BOX_Y, CFG_W'(by));
    set_reg(REG_BOX_Z, CFG_W'(bz));
    set_reg(REG_STEP, CFG_W'(st));
    set_reg(REG_COUNT, CFG_W'(cnt));
  endtask

  task automatic run_random(int n);
    int lim, idx;
    lim = (scan_count > NPART) ? NPART : scan_count;
    for (int i = 0; i < lim; i++)
      if (!loaded[i]) push_load(i, rand_pos(lbox_x), rand_pos(lbox_y), rand_pos(lbox_z));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 30) begin
        idx = ($urandom_range(3) == 0) ? $urandom_range(NPART - 1)
                                       : $urandom_range((lim > 0 ? lim : 1) - 1);
        push_load(idx, rand_pos(lbox_x), rand_pos(lbox_y), rand_pos(lbox_z));
      end else begin
        do idx = $urandom_range(NPART - 1); while (!loaded[idx] && $urandom_range(7) != 0);
        if (!loaded[idx]) idx = 0;
        push_move(idx, rand_frac(), rand_frac(), rand_frac());
      end
    end
  endtask

  initial begin
    lbox_x = 524288;
    lbox_y = 524288;
    lbox_z = 524288;
    lstep = 3277;
    scan_count = 500;
    n_accept = '0;
    n_reject = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_reg(REG_COUNT, 4);
    push_load(0, 0, 0, 0);
    push_load(1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    push_load(2, 24'h040000, 24'h040000, 24'h040000);
    push_load(3, 24'h018000, 24'h000000, 24'h000000);
    push_move(2, 0, 0, 0);
    push_move(2, 65536, 65536, 65536);
    push_move(2, 32768, 32768, 32768);
    push_move(3, 0, 32768, 32768);
    push_move(1, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    push_load(511, 24'h020000, 24'h070000, 24'h030000);
    push_move(511, 1000, 60000, 17'h1FFFF);
    set_reg(REG_STEP, 65536);
    push_move(0, 0, 0, 0);
    push_move(0, 17'h1FFFF, 0, 17'h1FFFF);
    set_reg(REG_BOX_X, 65536);
    push_move(1, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    push_move(1, 0, 0, 0);
    set_reg(REG_STEP, 0);
    push_move(2, 17'h1FFFF, 0, 12345);
    set_reg(REG_COUNT, 0);
    push_move(3, 0, 0, 0);
    push_move(511, 65536, 0, 65536);

    send_idle_pct = 0; stall_pct = 0;
    configure(524288, 524288, 524288, 3277, 16);
    run_random(200);

    send_idle_pct = 50; stall_pct = 0;
    configure($urandom_range(131072, 393216), $urandom_range(131072, 393216),
              $urandom_range(131072, 393216), 65536, 10);
    run_random(200);

    send_idle_pct = 0; stall_pct = 50;
    configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 1);
    run_random(150);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;

    send_idle_pct = 26; stall_pct = 26;
    configure(65536, 65536, 65536, 20000, 8);
    run_random(150);

    configure(1048576, 786432, 917504, 40000, 512);
    run_random(20);

    configure(1048576, 786432, 917504, 65536, 1023);
    run_random(10);

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && move_result_q.size() == 0) begin
      $display("PASS hard_sphere_metropolis_move");
    end else begin
      $display("FAIL hard_sphere_metropolis_move");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/hsm_pkg.sv
design/hsm_stream_if.sv
design/hsm_image_sq.sv
design/hard_sphere_metropolis_move.sv
dv/tb.sv
